// File: rtl/tvp_pkg.sv
// package: shared constants, codes and types of the trapezoid velocity profile block
`timescale 1ns / 1ps

package tvp_pkg;

    localparam int DistW = 32;
    localparam int VelW  = 22;
    localparam int WorkW = 64;
    localparam int CfgIdxW = 2;

    localparam logic [CfgIdxW-1:0] REG_SPEED_LIMIT = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_CREEP_SPEED = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_ACCEL_RATE  = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_CREEP_TIME  = 2'd3;

    localparam logic [VelW-1:0] SPEED_LIMIT_RST = VelW'(500000);
    localparam logic [VelW-1:0] CREEP_SPEED_RST = VelW'(20000);
    localparam logic [VelW-1:0] ACCEL_RATE_RST  = VelW'(500000);
    localparam logic [15:0]     CREEP_TIME_RST  = 16'd500;

    localparam logic [WorkW-1:0] MS_PER_S  = WorkW'(1000);
    localparam logic [WorkW-1:0] TWO_MS    = WorkW'(2000);
    localparam logic [WorkW-1:0] VEL_MAX   = WorkW'((64'd1 << VelW) - 64'd1);

    typedef enum logic [1:0] {
        ALU_MUL  = 2'd0,
        ALU_DIV  = 2'd1,
        ALU_SQRT = 2'd2
    } alu_op_t;

    typedef struct packed {
        logic             start;
        alu_op_t          op;
        logic [WorkW-1:0] arg_a;
        logic [WorkW-1:0] arg_b;
    } alu_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [WorkW-1:0] res;
        logic [WorkW-1:0] rem;
    } alu_rsp_t;

endpackage

// File: rtl/tvp_alu.sv
// shared bit-serial unit: shift-add multiply, restoring divide, digit-by-digit square root
`timescale 1ns / 1ps

module tvp_alu
(
    input  logic              clk,
    input  logic              rst_n,
    input  tvp_pkg::alu_req_t req,
    output tvp_pkg::alu_rsp_t rsp
);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    tvp_pkg::alu_op_t           op_reg, op_next;
    logic [5:0]                 cnt_reg, cnt_next;
    logic [tvp_pkg::WorkW+1:0]  r_reg, r_next;
    logic [tvp_pkg::WorkW-1:0]  q_reg, q_next;
    logic [tvp_pkg::WorkW-1:0]  y_reg, y_next;
    logic [tvp_pkg::WorkW+1:0]  shifted;
    logic [tvp_pkg::WorkW+1:0]  trial;
    logic                       last;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        r_next    = r_reg;
        q_next    = q_reg;
        y_next    = y_reg;
        shifted   = '0;
        trial     = '0;
        last      = 1'b0;
        if (!busy_reg)
        begin
            if (req.start)
            begin
                busy_next = 1'b1;
                op_next   = req.op;
                cnt_next  = '0;
                r_next    = '0;
                case (req.op)
                    tvp_pkg::ALU_MUL:
                    begin
                        q_next = req.arg_b;
                        y_next = req.arg_a;
                    end
                    tvp_pkg::ALU_DIV:
                    begin
                        q_next = req.arg_a;
                        y_next = req.arg_b;
                    end
                    default:
                    begin
                        q_next = '0;
                        y_next = req.arg_a;
                    end
                endcase
            end
        end
        else
        begin
            case (op_reg)
                tvp_pkg::ALU_MUL:
                begin
                    // multiplier bit by bit from the bottom
                    if (q_reg[0])
                    begin
                        r_next = r_reg + {2'b00, y_reg};
                    end
                    y_next = {y_reg[tvp_pkg::WorkW-2:0], 1'b0};
                    q_next = {1'b0, q_reg[tvp_pkg::WorkW-1:1]};
                    last   = (cnt_reg == 6'd63);
                end
                tvp_pkg::ALU_DIV:
                begin
                    shifted = {r_reg[tvp_pkg::WorkW:0], q_reg[tvp_pkg::WorkW-1]};
                    trial   = {2'b00, y_reg};
                    if (shifted >= trial)
                    begin
                        r_next = shifted - trial;
                        q_next = {q_reg[tvp_pkg::WorkW-2:0], 1'b1};
                    end
                    else
                    begin
                        r_next = shifted;
                        q_next = {q_reg[tvp_pkg::WorkW-2:0], 1'b0};
                    end
                    last = (cnt_reg == 6'd63);
                end
                default:
                begin
                    // two radicand bits per step, one root bit out
                    shifted = {r_reg[tvp_pkg::WorkW-1:0], y_reg[tvp_pkg::WorkW-1 -: 2]};
                    trial   = {32'd0, q_reg[31:0], 2'b01};
                    if (shifted >= trial)
                    begin
                        r_next = shifted - trial;
                        q_next = {q_reg[tvp_pkg::WorkW-2:0], 1'b1};
                    end
                    else
                    begin
                        r_next = shifted;
                        q_next = {q_reg[tvp_pkg::WorkW-2:0], 1'b0};
                    end
                    y_next = {y_reg[tvp_pkg::WorkW-3:0], 2'b00};
                    last   = (cnt_reg == 6'd31);
                end
            endcase
            cnt_next = cnt_reg + 6'd1;
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= tvp_pkg::ALU_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        q_reg <= q_next;
        y_reg <= y_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.res  = (op_reg == tvp_pkg::ALU_MUL) ? r_reg[tvp_pkg::WorkW-1:0] : q_reg;
    assign rsp.rem  = r_reg[tvp_pkg::WorkW-1:0];

endmodule

// File: rtl/trapezoid_velocity_profile.sv
// top level: move planner and per-sample velocity generator with a shared serial unit
`timescale 1ns / 1ps

// channel   direction  handshake             payload
// in        sink       in_valid / in_ready   op, move_distance, move_tolerance, position
// out       source     out_valid / out_ready vel_cmd, in_progress, move_accepted
// cfg       sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// one item at a time; each multiply and divide in the shared unit is 64 bit steps
// and a square root 32, plus the issue and wait states of the sequencer around each operation
// a planned start runs 14 to 18 operations
// a creep-only start runs two operations
// a sample on a ramp takes three operations; any other item is answered from setup
// reset clears the plan to an empty profile and loads the register defaults
// a finished result waits in the output register; the next item is taken meanwhile,
// and its own result holds in place until the output register is free

module trapezoid_velocity_profile
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [31:0] move_distance,
    input  logic [15:0] move_tolerance,
    input  logic [31:0] position,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [22:0] vel_cmd,
    output logic        in_progress,
    output logic        move_accepted,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [21:0] cfg_data
);

    localparam int W  = tvp_pkg::WorkW;
    localparam int VW = tvp_pkg::VelW;
    localparam int DW = tvp_pkg::DistW;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SETUP = 4'b0010,
        ST_ISSUE = 4'b0100,
        ST_WAIT  = 4'b1000
    } state_t;

    // sequencer steps: plan first, then the sample ramps
    typedef enum logic [4:0] {
        PL_MC, PL_C, PL_RA, PL_VV, PL_MM, PL_SQ, PL_TM, PL_TD,
        PL_AV, PL_NM, PL_ND, PL_XD, PL_Q1, PL_R1, PL_R2,
        PL_PA, PL_PD, PL_RM, PL_RD, PL_CM, PL_CD,
        SP_M1, SP_M2, SP_SQ
    } step_t;

    state_t state_reg, state_next;
    step_t  step_reg, step_next;

    // configuration
    logic [VW-1:0] speed_limit_reg, creep_speed_reg, accel_rate_reg;
    logic [15:0]   creep_time_reg;

    // plan state
    logic          dir_neg_reg, dir_neg_next;
    logic [VW-1:0] peak_reg, peak_next;
    logic [DW-1:0] ramp_reg, ramp_next;
    logic [DW-1:0] cruise_reg, cruise_next;
    logic [DW-1:0] creep_reg, creep_next;
    logic [15:0]   tol_reg, tol_next;

    // latched item
    logic          op_reg;
    logic [31:0]   dist_reg;
    logic [15:0]   mtol_reg;
    logic [31:0]   pos_reg;

    // working values of the sequencer
    logic [W-1:0]  d_reg, d_next;
    logic [W-1:0]  tmp_reg, tmp_next;
    logic [W-1:0]  ra_reg, ra_next;
    logic [W-1:0]  mm_reg, mm_next;
    logic [W-1:0]  x_reg, x_next;
    logic [W-1:0]  av_reg, av_next;
    logic [W-1:0]  t_reg, t_next;
    logic [W-1:0]  cms_reg, cms_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  pk_reg, pk_next;
    logic [W-1:0]  rmp_reg, rmp_next;
    logic          accel_reg, accel_next;

    // output register
    logic          out_valid_reg, out_valid_next;
    logic [VW-1:0] omag_reg, omag_next;
    logic          oneg_reg, oneg_next;
    logic          obusy_reg, obusy_next;
    logic          oacc_reg, oacc_next;

    // unit results stay in its registers, so a stalled finish can retry next cycle
    logic          hold_done_reg;

    tvp_pkg::alu_req_t alu_req;
    tvp_pkg::alu_rsp_t alu_rsp;

    logic [W-1:0]  vmin, a_eff, v_lim;
    logic [W-1:0]  dist_abs, span, used, root_cap;
    logic signed [W-1:0] p_s, r_s, c_s, tot_s, tol_s;
    logic          res_ready;

    tvp_alu u_alu
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    assign vmin     = {{(W-VW){1'b0}}, creep_speed_reg};
    assign a_eff    = (accel_rate_reg == '0) ? W'(1) : {{(W-VW){1'b0}}, accel_rate_reg};
    // effective speed limit: never below creep, never zero
    assign v_lim    = (speed_limit_reg > creep_speed_reg)
                      ? {{(W-VW){1'b0}}, speed_limit_reg}
                      : ((creep_speed_reg == '0) ? W'(1) : vmin);
    assign dist_abs = dist_reg[31] ? {{(W-DW){1'b0}}, (~dist_reg + 32'd1)}
                                   : {{(W-DW){1'b0}}, dist_reg};
    assign span     = tmp_reg - alu_rsp.res;
    assign used     = {rmp_reg[W-2:0], 1'b0} + alu_rsp.res;
    assign root_cap = (alu_rsp.res > tvp_pkg::VEL_MAX) ? tvp_pkg::VEL_MAX : alu_rsp.res;

    // travelled distance along the move direction
    assign p_s   = dir_neg_reg ? -W'(signed'(pos_reg)) : W'(signed'(pos_reg));
    assign r_s   = signed'({{(W-DW){1'b0}}, ramp_reg});
    assign c_s   = signed'({{(W-DW){1'b0}}, cruise_reg});
    assign tot_s = (r_s <<< 1) + c_s + signed'({{(W-DW){1'b0}}, creep_reg});
    assign tol_s = signed'({{(W-16){1'b0}}, tol_reg});

    assign res_ready = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_limit_reg <= tvp_pkg::SPEED_LIMIT_RST;
            creep_speed_reg <= tvp_pkg::CREEP_SPEED_RST;
            accel_rate_reg  <= tvp_pkg::ACCEL_RATE_RST;
            creep_time_reg  <= tvp_pkg::CREEP_TIME_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tvp_pkg::REG_SPEED_LIMIT: speed_limit_reg <= cfg_data;
                tvp_pkg::REG_CREEP_SPEED: creep_speed_reg <= cfg_data;
                tvp_pkg::REG_ACCEL_RATE:  accel_rate_reg  <= cfg_data;
                tvp_pkg::REG_CREEP_TIME:  creep_time_reg  <= cfg_data[15:0];
                default:                  creep_time_reg  <= creep_time_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        dir_neg_next   = dir_neg_reg;
        peak_next      = peak_reg;
        ramp_next      = ramp_reg;
        cruise_next    = cruise_reg;
        creep_next     = creep_reg;
        tol_next       = tol_reg;
        d_next         = d_reg;
        tmp_next       = tmp_reg;
        ra_next        = ra_reg;
        mm_next        = mm_reg;
        x_next         = x_reg;
        av_next        = av_reg;
        t_next         = t_reg;
        cms_next       = cms_reg;
        rem_next       = rem_reg;
        pk_next        = pk_reg;
        rmp_next       = rmp_reg;
        accel_next     = accel_reg;
        out_valid_next = out_valid_reg && !out_ready;
        omag_next      = omag_reg;
        oneg_next      = oneg_reg;
        obusy_next     = obusy_reg;
        oacc_next      = oacc_reg;
        alu_req.start  = 1'b0;
        alu_req.op     = tvp_pkg::ALU_MUL;
        alu_req.arg_a  = '0;
        alu_req.arg_b  = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SETUP;
                end
            end

            ST_SETUP:
            begin
                if (!op_reg)
                begin
                    if (dist_abs < {{(W-16){1'b0}}, mtol_reg})
                    begin
                        // rejected start: plan untouched
                        if (res_ready)
                        begin
                            out_valid_next = 1'b1;
                            omag_next      = '0;
                            oneg_next      = 1'b0;
                            obusy_next     = 1'b0;
                            oacc_next      = 1'b0;
                            state_next     = ST_IDLE;
                        end
                    end
                    else
                    begin
                        tol_next     = mtol_reg;
                        dir_neg_next = (dist_reg[31] || (dist_reg == '0));
                        d_next       = dist_abs;
                        step_next    = PL_MC;
                        state_next   = ST_ISSUE;
                    end
                end
                else if (p_s < 0)
                begin
                    if (res_ready)
                    begin
                        out_valid_next = 1'b1;
                        omag_next      = creep_speed_reg;
                        oneg_next      = dir_neg_reg;
                        obusy_next     = 1'b1;
                        oacc_next      = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end
                else if (p_s < r_s)
                begin
                    accel_next = 1'b1;
                    tmp_next   = W'(p_s <<< 1);
                    step_next  = SP_M1;
                    state_next = ST_ISSUE;
                end
                else if (p_s < r_s + c_s)
                begin
                    if (res_ready)
                    begin
                        out_valid_next = 1'b1;
                        omag_next      = peak_reg;
                        oneg_next      = dir_neg_reg;
                        obusy_next     = 1'b1;
                        oacc_next      = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end
                else if (p_s < (r_s <<< 1) + c_s)
                begin
                    accel_next = 1'b0;
                    tmp_next   = W'((p_s - r_s - c_s) <<< 1);
                    step_next  = SP_M1;
                    state_next = ST_ISSUE;
                end
                else if (res_ready)
                begin
                    // creep, reverse creep past the goal, or arrived
                    out_valid_next = 1'b1;
                    oacc_next      = 1'b0;
                    if (p_s < tot_s - tol_s)
                    begin
                        omag_next  = creep_speed_reg;
                        oneg_next  = dir_neg_reg;
                        obusy_next = 1'b1;
                    end
                    else if (p_s > tot_s + tol_s)
                    begin
                        omag_next  = creep_speed_reg;
                        oneg_next  = !dir_neg_reg;
                        obusy_next = 1'b1;
                    end
                    else
                    begin
                        omag_next  = '0;
                        oneg_next  = 1'b0;
                        obusy_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_ISSUE:
            begin
                alu_req.start = 1'b1;
                state_next    = ST_WAIT;
                case (step_reg)
                    PL_MC:
                    begin
                        alu_req.arg_a = vmin;
                        alu_req.arg_b = {{(W-16){1'b0}}, creep_time_reg};
                    end
                    PL_C, PL_TD, PL_ND, PL_XD, PL_R2, PL_PD, PL_RD, PL_CD:
                    begin
                        alu_req.op = tvp_pkg::ALU_DIV;
                        case (step_reg)
                            PL_TD, PL_ND:
                            begin
                                alu_req.arg_a = tmp_reg;
                                alu_req.arg_b = a_eff;
                            end
                            PL_XD:
                            begin
                                alu_req.arg_a = x_reg;
                                alu_req.arg_b = av_reg;
                            end
                            PL_R2:
                            begin
                                alu_req.arg_a = tmp_reg;
                                alu_req.arg_b = av_reg;
                            end
                            PL_RD:
                            begin
                                alu_req.arg_a = tmp_reg;
                                alu_req.arg_b = tvp_pkg::TWO_MS;
                            end
                            default:
                            begin
                                alu_req.arg_a = tmp_reg;
                                alu_req.arg_b = tvp_pkg::MS_PER_S;
                            end
                        endcase
                    end
                    PL_RA:
                    begin
                        alu_req.arg_a = ra_reg;
                        alu_req.arg_b = a_eff;
                    end
                    PL_VV:
                    begin
                        alu_req.arg_a = v_lim;
                        alu_req.arg_b = v_lim;
                    end
                    PL_MM:
                    begin
                        alu_req.arg_a = vmin;
                        alu_req.arg_b = vmin;
                    end
                    PL_SQ:
                    begin
                        alu_req.op    = tvp_pkg::ALU_SQRT;
                        alu_req.arg_a = ra_reg + mm_reg;
                    end
                    PL_TM, PL_Q1:
                    begin
                        alu_req.arg_a = tmp_reg;
                        alu_req.arg_b = tvp_pkg::MS_PER_S;
                    end
                    PL_AV:
                    begin
                        alu_req.arg_a = a_eff;
                        alu_req.arg_b = v_lim;
                    end
                    PL_NM:
                    begin
                        alu_req.arg_a = v_lim - vmin;
                        alu_req.arg_b = tvp_pkg::MS_PER_S;
                    end
                    PL_R1:
                    begin
                        alu_req.arg_a = rem_reg;
                        alu_req.arg_b = tvp_pkg::MS_PER_S;
                    end
                    PL_PA:
                    begin
                        alu_req.arg_a = t_reg;
                        alu_req.arg_b = a_eff;
                    end
                    PL_RM:
                    begin
                        alu_req.arg_a = pk_reg + vmin;
                        alu_req.arg_b = t_reg;
                    end
                    PL_CM:
                    begin
                        alu_req.arg_a = pk_reg;
                        alu_req.arg_b = cms_reg;
                    end
                    SP_M1:
                    begin
                        alu_req.arg_a = tmp_reg;
                        alu_req.arg_b = a_eff;
                    end
                    SP_M2:
                    begin
                        alu_req.arg_a = accel_reg ? vmin : {{(W-VW){1'b0}}, peak_reg};
                        alu_req.arg_b = alu_req.arg_a;
                    end
                    default:
                    begin
                        // square root on a ramp, clamped at zero on the way down
                        alu_req.op    = tvp_pkg::ALU_SQRT;
                        alu_req.arg_a = accel_reg ? (ra_reg + tmp_reg)
                                        : ((ra_reg < tmp_reg) ? (tmp_reg - ra_reg) : '0);
                    end
                endcase
            end

            ST_WAIT:
            begin
                if (alu_rsp.done || hold_done_reg)
                begin
                    state_next = ST_ISSUE;
                    case (step_reg)
                        PL_MC:
                        begin
                            tmp_next  = alu_rsp.res;
                            step_next = PL_C;
                        end
                        PL_C:
                        begin
                            if (d_reg < alu_rsp.res)
                            begin
                                // short move: creep only
                                if (res_ready)
                                begin
                                    ramp_next      = '0;
                                    cruise_next    = '0;
                                    creep_next     = d_reg[DW-1:0];
                                    peak_next      = creep_speed_reg;
                                    out_valid_next = 1'b1;
                                    omag_next      = '0;
                                    oneg_next      = 1'b0;
                                    obusy_next     = 1'b1;
                                    oacc_next      = 1'b1;
                                    state_next     = ST_IDLE;
                                end
                                else
                                begin
                                    state_next = ST_WAIT;
                                end
                            end
                            else
                            begin
                                ra_next   = d_reg - alu_rsp.res;
                                step_next = PL_RA;
                            end
                        end
                        PL_RA:
                        begin
                            ra_next   = alu_rsp.res;
                            step_next = PL_VV;
                        end
                        PL_VV:
                        begin
                            tmp_next  = alu_rsp.res;
                            step_next = PL_MM;
                        end
                        PL_MM:
                        begin
                            mm_next = alu_rsp.res;
                            x_next  = ra_reg - span;
                            step_next = (ra_reg < span) ? PL_SQ : PL_AV;
                        end
                        PL_SQ:
                        begin
                            tmp_next  = (alu_rsp.res > vmin) ? (alu_rsp.res - vmin) : '0;
                            step_next = PL_TM;
                        end
                        PL_TM, PL_NM, PL_R1:
                        begin
                            tmp_next  = alu_rsp.res;
                            step_next = (step_reg == PL_TM) ? PL_TD
                                      : ((step_reg == PL_NM) ? PL_ND : PL_R2);
                        end
                        PL_TD:
                        begin
                            t_next    = alu_rsp.res;
                            cms_next  = '0;
                            step_next = PL_PA;
                        end
                        PL_AV:
                        begin
                            av_next   = alu_rsp.res;
                            step_next = PL_NM;
                        end
                        PL_ND:
                        begin
                            t_next    = alu_rsp.res;
                            step_next = PL_XD;
                        end
                        PL_XD:
                        begin
                            tmp_next  = alu_rsp.res;
                            rem_next  = alu_rsp.rem;
                            step_next = PL_Q1;
                        end
                        PL_Q1:
                        begin
                            cms_next  = alu_rsp.res;
                            step_next = PL_R1;
                        end
                        PL_R2:
                        begin
                            cms_next  = cms_reg + alu_rsp.res;
                            step_next = PL_PA;
                        end
                        PL_PA, PL_RM, PL_CM:
                        begin
                            tmp_next  = alu_rsp.res;
                            step_next = (step_reg == PL_PA) ? PL_PD
                                      : ((step_reg == PL_RM) ? PL_RD : PL_CD);
                        end
                        PL_PD:
                        begin
                            pk_next   = ((vmin + alu_rsp.res) > tvp_pkg::VEL_MAX)
                                        ? tvp_pkg::VEL_MAX : (vmin + alu_rsp.res);
                            step_next = PL_RM;
                        end
                        PL_RD:
                        begin
                            rmp_next  = alu_rsp.res;
                            step_next = PL_CM;
                        end
                        PL_CD:
                        begin
                            if (res_ready)
                            begin
                                peak_next   = pk_reg[VW-1:0];
                                ramp_next   = rmp_reg[DW-1:0];
                                cruise_next = alu_rsp.res[DW-1:0];
                                creep_next  = (d_reg > used) ? DW'(d_reg - used) : '0;
                                out_valid_next = 1'b1;
                                omag_next   = '0;
                                oneg_next   = 1'b0;
                                obusy_next  = 1'b1;
                                oacc_next   = 1'b1;
                                state_next  = ST_IDLE;
                            end
                            else
                            begin
                                state_next = ST_WAIT;
                            end
                        end
                        SP_M1:
                        begin
                            ra_next   = alu_rsp.res;
                            step_next = SP_M2;
                        end
                        SP_M2:
                        begin
                            tmp_next  = alu_rsp.res;
                            step_next = SP_SQ;
                        end
                        default:
                        begin
                            if (res_ready)
                            begin
                                out_valid_next = 1'b1;
                                omag_next   = root_cap[VW-1:0];
                                oneg_next   = dir_neg_reg;
                                obusy_next  = 1'b1;
                                oacc_next   = 1'b0;
                                state_next  = ST_IDLE;
                            end
                            else
                            begin
                                state_next = ST_WAIT;
                            end
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= PL_MC;
            out_valid_reg <= 1'b0;
            hold_done_reg <= 1'b0;
            dir_neg_reg   <= 1'b0;
            peak_reg      <= '0;
            ramp_reg      <= '0;
            cruise_reg    <= '0;
            creep_reg     <= '0;
            tol_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            hold_done_reg <= (state_reg == ST_WAIT) && (state_next == ST_WAIT)
                             && (alu_rsp.done || hold_done_reg);
            dir_neg_reg   <= dir_neg_next;
            peak_reg      <= peak_next;
            ramp_reg      <= ramp_next;
            cruise_reg    <= cruise_next;
            creep_reg     <= creep_next;
            tol_reg       <= tol_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg   <= op;
            dist_reg <= move_distance;
            mtol_reg <= move_tolerance;
            pos_reg  <= position;
        end
        d_reg    <= d_next;
        tmp_reg  <= tmp_next;
        ra_reg   <= ra_next;
        mm_reg   <= mm_next;
        x_reg    <= x_next;
        av_reg   <= av_next;
        t_reg    <= t_next;
        cms_reg  <= cms_next;
        rem_reg  <= rem_next;
        pk_reg   <= pk_next;
        rmp_reg  <= rmp_next;
        accel_reg <= accel_next;
        omag_reg <= omag_next;
        oneg_reg <= oneg_next;
        obusy_reg <= obusy_next;
        oacc_reg <= oacc_next;
    end

    assign out_valid     = out_valid_reg;
    assign vel_cmd       = oneg_reg ? (~{1'b0, omag_reg} + 23'd1) : {1'b0, omag_reg};
    assign in_progress   = obusy_reg;
    assign move_accepted = oacc_reg;

    a_accept_to_setup: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_SETUP))
        else $error("accepted item did not enter setup");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        alu_rsp.done |-> (state_reg == ST_WAIT))
        else $error("serial unit finished outside wait state");

    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        alu_req.start |-> !alu_rsp.busy)
        else $error("serial unit started while busy");

    a_reject_keeps_plan: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SETUP) && !op_reg
         && (dist_abs < {{(W-16){1'b0}}, mtol_reg}))
        |=> ($stable(ramp_reg) && $stable(tol_reg) && $stable(dir_neg_reg)))
        else $error("rejected start changed the plan");

endmodule

// File: dv/tb_trapezoid_velocity_profile.sv
// testbench: directed and randomised move plans and position samples checked against a built-in profile predictor
`timescale 1ns / 1ps

module tb_trapezoid_velocity_profile;

    // item opcodes on the op port
    localparam logic OP_START  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam int          HOLD_CYCLES = 3000;
    localparam logic [63:0] VEL_CAP     = (64'd1 << 22) - 64'd1;
    localparam logic [63:0] LEN_MASK    = 64'h0000_0000_ffff_ffff;

    typedef struct {
        logic        op;
        logic [31:0] travel;
        logic [15:0] tol;
        logic [31:0] pos;
    } motion_item_t;

    typedef struct {
        logic [22:0] vel;
        logic        busy;
        logic        accepted;
    } command_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        op;
    logic [31:0] move_distance;
    logic [15:0] move_tolerance;
    logic [31:0] position;
    logic        out_valid;
    logic        out_ready;
    logic [22:0] vel_cmd;
    logic        in_progress;
    logic        move_accepted;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [21:0] cfg_data;

    trapezoid_velocity_profile dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .op              (op),
        .move_distance   (move_distance),
        .move_tolerance  (move_tolerance),
        .position        (position),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .vel_cmd         (vel_cmd),
        .in_progress     (in_progress),
        .move_accepted   (move_accepted),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // items waiting to be offered, and commands still owed by the block
    motion_item_t pending_moves[$];
    command_t     commands_due[$];
    motion_item_t offered;

    // predictor copy of the registers
    logic [63:0] lim_speed, creep_vel, accel, creep_ms;
    // predictor copy of the stored plan
    logic        plan_neg;
    logic [63:0] plan_peak, plan_ramp, plan_cruise, plan_creep, plan_tol;

    // idling percentages for the current phase
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    // long receiver hold-off, requested by toggling hold_req
    logic hold_req, hold_seen;
    int   hold_left;

    int errors, n_starts, n_rejected, n_samples, n_settled, n_cfg_writes;

    always #1 clk = ~clk;

    function automatic logic [63:0] floor_root(logic [63:0] x);
        logic [63:0] r, b;
        r = 64'd0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 64'd0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // accel register of zero behaves as one
    function automatic logic [63:0] live_accel();
        return (accel == 64'd0) ? 64'd1 : accel;
    endfunction

    // lay out ramp, cruise and creep lengths for a move of length dist_abs
    function automatic void plan_move(logic [63:0] dist_abs);
        logic [63:0] vmin, a, vtop, creep_span, rest, span, t, cms, pk, rmp, crs, used, x, av, top;
        vmin = creep_vel;
        a    = live_accel();
        vtop = (lim_speed > vmin) ? lim_speed : vmin;
        if (vtop == 64'd0)
            vtop = 64'd1;
        cms = 64'd0;
        creep_span = vmin * creep_ms / 64'd1000;
        if (dist_abs < creep_span)
        begin
            // too short to ramp at all: creep the whole way
            plan_ramp   = 64'd0;
            plan_cruise = 64'd0;
            plan_creep  = dist_abs & LEN_MASK;
            plan_peak   = vmin;
            return;
        end
        rest = dist_abs - creep_span;
        span = vtop * vtop - vmin * vmin;
        if (rest * a < span)
        begin
            // triangular profile, peak below the speed limit
            top = floor_root(rest * a + vmin * vmin);
            t   = ((top > vmin) ? top - vmin : 64'd0) * 64'd1000 / a;
        end
        else
        begin
            x   = rest * a - span;
            av  = a * vtop;
            t   = (vtop - vmin) * 64'd1000 / a;
            cms = (x / av) * 64'd1000 + (x % av) * 64'd1000 / av;
        end
        pk = vmin + t * a / 64'd1000;
        if (pk > VEL_CAP)
            pk = VEL_CAP;
        rmp  = (pk + vmin) * t / 64'd2000;
        crs  = pk * cms / 64'd1000;
        used = 64'd2 * rmp + crs;
        plan_peak   = pk;
        plan_ramp   = rmp & LEN_MASK;
        plan_cruise = crs & LEN_MASK;
        plan_creep  = ((dist_abs > used) ? dist_abs - used : 64'd0) & LEN_MASK;
    endfunction

    // expected command for one accepted item; updates the stored plan on starts that are not refused
    function automatic command_t predict_command(motion_item_t it);
        command_t    cmd;
        longint      d, p, r, c, tot, tl;
        logic [63:0] dist_abs, vmin, a, mag, pk2, sub;
        logic        neg, busy;
        vmin = creep_vel;
        a    = live_accel();
        mag  = 64'd0;
        neg  = 1'b0;
        busy = 1'b1;
        if (it.op == OP_START)
        begin
            d = longint'($signed(it.travel));
            dist_abs = (d < 0) ? 64'(-d) : 64'(d);
            cmd.vel = 23'd0;
            if (dist_abs < {48'd0, it.tol})
            begin
                cmd.busy = 1'b0;
                cmd.accepted = 1'b0;
            end
            else
            begin
                plan_tol = {48'd0, it.tol};
                // zero distance counts as a move in the negative direction
                plan_neg = !(d > 0);
                plan_move(dist_abs);
                cmd.busy = 1'b1;
                cmd.accepted = 1'b1;
            end
            return cmd;
        end
        p   = longint'($signed(it.pos));
        r   = longint'(plan_ramp);
        c   = longint'(plan_cruise);
        tot = 2 * r + c + longint'(plan_creep);
        tl  = longint'(plan_tol);
        if (plan_neg)
            p = -p;
        if (p < 0)
            mag = vmin;
        else if (p < r)
            mag = floor_root(64'd2 * 64'(p) * a + vmin * vmin);
        else if (p < r + c)
            mag = plan_peak;
        else if (p < 2 * r + c)
        begin
            pk2 = plan_peak * plan_peak;
            sub = 64'd2 * 64'(p - r - c) * a;
            mag = (sub < pk2) ? floor_root(pk2 - sub) : 64'd0;
        end
        else if (p < tot - tl)
            mag = vmin;
        else if (p > tot + tl)
        begin
            // overshoot: creep back
            mag = vmin;
            neg = 1'b1;
        end
        else
            busy = 1'b0;
        if (mag > VEL_CAP)
            mag = VEL_CAP;
        if (plan_neg)
            neg = !neg;
        cmd.vel      = neg ? 23'(64'd0 - mag) : 23'(mag);
        cmd.busy     = busy;
        cmd.accepted = 1'b0;
        return cmd;
    endfunction

    // input driver: valid held with a stable payload until the transfer completes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid       <= 1'b0;
            op             <= OP_START;
            move_distance  <= '0;
            move_tolerance <= '0;
            position       <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                commands_due.push_back(predict_command(offered));
                if (offered.op == OP_START)
                begin
                    n_starts++;
                    if (!commands_due[$].accepted)
                        n_rejected++;
                end
                else
                    n_samples++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_moves.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    offered        = pending_moves.pop_front();
                    in_valid       <= 1'b1;
                    op             <= offered.op;
                    move_distance  <= offered.travel;
                    move_tolerance <= offered.tol;
                    position       <= offered.pos;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // hold-off counter, armed from the stimulus process by toggling hold_req
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_seen <= 1'b0;
        end
        else if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // result side: random back-pressure plus the long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end

    // result monitor: every transfer is matched against the oldest command due
    always @(posedge clk)
    begin
        command_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (commands_due.size() == 0)
            begin
                $error("result transfer with nothing expected: vel %0d", $signed(vel_cmd));
                errors++;
            end
            else
            begin
                want = commands_due.pop_front();
                if (vel_cmd !== want.vel)
                begin
                    $error("vel_cmd: expected %0d, got %0d",
                           $signed(want.vel), $signed(vel_cmd));
                    errors++;
                end
                if (in_progress !== want.busy)
                begin
                    $error("in_progress: expected %0b, got %0b", want.busy, in_progress);
                    errors++;
                end
                if (move_accepted !== want.accepted)
                begin
                    $error("move_accepted: expected %0b, got %0b", want.accepted, move_accepted);
                    errors++;
                end
                if (!want.busy)
                    n_settled++;
            end
        end
    end

    // register writes land in the predictor at the transfer edge
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            n_cfg_writes++;
            case (cfg_index)
                tvp_pkg::REG_SPEED_LIMIT: lim_speed = {42'd0, cfg_data};
                tvp_pkg::REG_CREEP_SPEED: creep_vel = {42'd0, cfg_data};
                tvp_pkg::REG_ACCEL_RATE:  accel     = {42'd0, cfg_data};
                tvp_pkg::REG_CREEP_TIME:  creep_ms  = {48'd0, cfg_data[15:0]};
                default: ;
            endcase
        end
    end

    // write all four registers back to back; valid stays up between writes
    task automatic write_regs(logic [21:0] spd, logic [21:0] crp, logic [21:0] acc,
                              logic [15:0] cms);
        logic [1:0]  idx[4];
        logic [21:0] val[4];
        int          seen;
        idx[0] = tvp_pkg::REG_SPEED_LIMIT; val[0] = spd;
        idx[1] = tvp_pkg::REG_CREEP_SPEED; val[1] = crp;
        idx[2] = tvp_pkg::REG_ACCEL_RATE;  val[2] = acc;
        idx[3] = tvp_pkg::REG_CREEP_TIME;  val[3] = {6'd0, cms};
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx[0];
        cfg_data  <= val[0];
        for (int k = 0; k < 4; k++)
        begin
            seen = n_cfg_writes;
            wait (n_cfg_writes != seen);
            if (k < 3)
            begin
                cfg_index <= idx[k + 1];
                cfg_data  <= val[k + 1];
            end
            else
                cfg_valid <= 1'b0;
        end
    endtask

    // block until every item has gone in and every command has come back
    task automatic drain();
        while (pending_moves.size() != 0 || in_valid || commands_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic queue_item(logic o, logic [31:0] d, logic [15:0] t, logic [31:0] p);
        motion_item_t it;
        it.op = o;
        it.travel = d;
        it.tol = t;
        it.pos = p;
        pending_moves.push_back(it);
    endtask

    // well-formed moves: a start then samples spread over the whole path,
    // with some fully random starts and samples mixed in as noise
    task automatic queue_moves(int count);
        int          made, nsamp;
        longint      d, span, pv;
        logic [15:0] t;
        logic [31:0] dv;
        made = 0;
        while (made < count)
        begin
            if ($urandom_range(9) == 0)
            begin
                dv = $urandom();
                t  = 16'($urandom());
            end
            else
            begin
                d  = longint'($urandom_range(2000000));
                if ($urandom_range(1))
                    d = -d;
                dv = 32'(d);
                t  = ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(200));
            end
            queue_item(OP_START, dv, t, $urandom());
            made++;
            d = longint'($signed(dv));
            span = ((d < 0) ? -d : d) + 2 * longint'(t) + 100;
            nsamp = $urandom_range(10, 3);
            for (int k = 0; k < nsamp && made < count; k++)
            begin
                if ($urandom_range(9) == 0)
                    queue_item(OP_SAMPLE, $urandom(), 16'($urandom()), $urandom());
                else
                begin
                    pv = longint'($urandom_range(32'(span > 64'hffff_ffff ? 32'hffff_ffff : span)))
                         - 50;
                    if (d <= 0)
                        pv = -pv;
                    queue_item(OP_SAMPLE, $urandom(), 16'($urandom()), 32'(pv));
                end
                made++;
            end
        end
    endtask

    task automatic set_idling(int mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
            default: begin send_idle_pct = 21; recv_stall_pct = 21; end
        endcase
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = tvp_pkg::REG_SPEED_LIMIT;
        cfg_data = '0;
        hold_req = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        errors = 0; n_starts = 0; n_rejected = 0; n_samples = 0; n_settled = 0;
        n_cfg_writes = 0;
        lim_speed = 64'(tvp_pkg::SPEED_LIMIT_RST);
        creep_vel = 64'(tvp_pkg::CREEP_SPEED_RST);
        accel     = 64'(tvp_pkg::ACCEL_RATE_RST);
        creep_ms  = 64'(tvp_pkg::CREEP_TIME_RST);
        plan_neg = 1'b0;
        plan_peak = 0; plan_ramp = 0; plan_cruise = 0; plan_creep = 0; plan_tol = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part on the reset registers
        // samples before any move see the empty profile
        queue_item(OP_SAMPLE, 32'd0, 16'd0, 32'd0);
        queue_item(OP_SAMPLE, 32'd0, 16'd0, 32'hffff_fffb);
        queue_item(OP_SAMPLE, 32'd0, 16'd0, 32'd100);
        // move shorter than its tolerance is refused
        queue_item(OP_START, 32'd5, 16'd10, 32'd0);
        // zero-length move: negative direction, settles at once
        queue_item(OP_START, 32'd0, 16'd0, 32'd0);
        queue_item(OP_SAMPLE, 32'd0, 16'd0, 32'd0);
        queue_item(OP_SAMPLE, 32'd0, 16'd0, 32'd1);
        // longest positive move, widest tolerance
        queue_item(OP_START, 32'h7fff_ffff, 16'hffff, 32'hffff_ffff);
        queue_item(OP_SAMPLE, 32'd0, 16'd0, 32'd0);
        queue_item(OP_SAMPLE, 32'd0, 16'd0, 32'd1000);
        queue_item(OP_SAMPLE, 32'd0, 16'd0, 32'h4000_0000);
        queue_item(OP_SAMPLE, 32'd0, 16'd0, 32'h7fff_ffff);
        queue_item(OP_SAMPLE, 32'd0, 16'd0, 32'h8000_0000);
        // most negative move
        queue_item(OP_START, 32'h8000_0000, 16'd0, 32'd0);
        queue_item(OP_SAMPLE, 32'd0, 16'd0, 32'hffff_fc18);
        queue_item(OP_SAMPLE, 32'd0, 16'd0, 32'h7fff_ffff);
        // creep-only move, shorter than the creep span
        queue_item(OP_START, 32'd3000, 16'd0, 32'd0);
        queue_item(OP_SAMPLE, 32'd0, 16'd0, 32'd1500);
        queue_item(OP_SAMPLE, 32'd0, 16'd0, 32'd3000);
        // ordinary move, samples either side of the goal band
        queue_item(OP_START, 32'd100000, 16'd100, 32'd0);
        queue_item(OP_SAMPLE, 32'd0, 16'd0, 32'd50000);
        queue_item(OP_SAMPLE, 32'd0, 16'd0, 32'd99950);
        queue_item(OP_SAMPLE, 32'd0, 16'd0, 32'd100000);
        queue_item(OP_SAMPLE, 32'd0, 16'd0, 32'd100200);
        drain();

        // random phases; each starts idle with fresh registers
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: write_regs(22'h3f_ffff, 22'd1, 22'h3f_ffff, 16'd0);
                1: write_regs(22'd1, 22'd20000, 22'd1, 16'hffff);
                2: write_regs(22'd300000, 22'h3f_ffff, 22'd0, 16'd1);
                3: write_regs(tvp_pkg::SPEED_LIMIT_RST, tvp_pkg::CREEP_SPEED_RST,
                              tvp_pkg::ACCEL_RATE_RST, tvp_pkg::CREEP_TIME_RST);
                default: write_regs(22'($urandom_range(4194303, 1)),
                                    22'($urandom_range(100000, 1)),
                                    22'($urandom_range(4194303, 1)),
                                    16'($urandom_range(2000)));
            endcase
            set_idling(ph);
            @(negedge clk);
            queue_moves(240);
            // once, starve the result side while items keep coming
            if (ph == 2)
                hold_req = ~hold_req;
            drain();
        end

        $display("covered %0d starts (%0d refused) and %0d samples over 9 register settings,",
                 n_starts, n_rejected, n_samples);
        $display("%0d results reported the move settled or refused", n_settled);
        if (errors == 0)
            $display("tb_trapezoid_velocity_profile: done, clean");
        else
            $display("tb_trapezoid_velocity_profile: done, errors");
        $finish;
    end

    // watchdog
    initial
    begin
        #40_000_000;
        $display("tb_trapezoid_velocity_profile: done, errors");
        $finish;
    end

endmodule

// File: sim.f
rtl/tvp_pkg.sv
rtl/tvp_alu.sv
rtl/trapezoid_velocity_profile.sv
dv/tb_trapezoid_velocity_profile.sv
